>>> rtl/core/pplr_pkg.sv
// ----------------------------------------------------------------------------
// pplr_pkg: shared types and constants
// Grid geometry, store word layout, fit sequencer command types and states.
// ----------------------------------------------------------------------------
package pplr_pkg;

    // grid and field geometry (grid sizes are powers of two: address is {row, col})
    localparam int GRID_ROWS    = 64;
    localparam int GRID_COLUMNS = 64;
    localparam int MAX_DAYS     = 512;
    localparam int ROW_W        = 6;
    localparam int COL_W        = 6;
    localparam int DAY_W        = 9;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_W        = 10;
    localparam int ADDR_W       = ROW_W + COL_W;
    localparam int DEPTH        = GRID_ROWS * GRID_COLUMNS;

    // store word: {sum_samples, sum_squared_samples, sum_day_weighted_samples}
    localparam int SUM_W  = 25;
    localparam int SQ_W   = 40;
    localparam int DW_W   = 34;
    localparam int WORD_W = SUM_W + SQ_W + DW_W;

    // fit datapath widths
    localparam int DP_W   = 64;
    localparam int PROD_W = 2 * DP_W;
    localparam int RAD_W  = 96;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 4;
    localparam int CNT_W  = 7;
    localparam int PC_W   = 5;

    // result field widths
    localparam int MEAN_W = 24;
    localparam int SLOPE_W = 32;
    localparam int ICPT_W = 32;
    localparam int CORR_W = 16;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_FIT      = 2'd0,
        ST_COLD     = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_SHR1,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [4:0] {
        R_ONE, R_SIX, R_TWELVE, R_C300,
        R_SV, R_SXV, R_SV2, R_N, R_NP1, R_NM1, R_NN, R_NNP1,
        R_T, R_DEN, R_SX, R_A, R_B, R_NUM, R_VDEN, R_INUM, R_S,
        R_MEAN, R_SLOPE, R_ICPT, R_CORR
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg a;
        t_reg b;
        t_reg dst;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_WR,
        S_REP_LOAD,
        S_EXEC,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_SQRT
    } t_unit;

    // named program points; the sequence branches at the mean, intercept, root and correlation points
    localparam logic [PC_W-1:0] PC_MEAN  = 5'd21;
    localparam logic [PC_W-1:0] PC_SLOPE = 5'd22;
    localparam logic [PC_W-1:0] PC_ICPT  = 5'd23;
    localparam logic [PC_W-1:0] PC_PROD  = 5'd24;
    localparam logic [PC_W-1:0] PC_SQRT  = 5'd25;
    localparam logic [PC_W-1:0] PC_CORR  = 5'd26;

    // controller to datapath
    typedef struct packed {
        logic    clr;
        logic    take;
        logic    acc_wr;
        logic    rep_load;
        logic    issue;
        t_cmd    cmd;
        logic    out_load;
        t_status status;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic busy;
        logic cold;
        logic den_le0;
        logic vden_gt0;
        logic s_zero;
    } t_sts;

    typedef struct packed {
        logic signed [MEAN_W-1:0]  mean;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
        logic signed [CORR_W-1:0]  corr;
        t_status                   status;
    } t_result;

endpackage

>>> rtl/core/pplr_if.sv
// ----------------------------------------------------------------------------
// pplr_if: input and output word channels
// Valid/ready channels carrying one item or one fit result.
// ----------------------------------------------------------------------------
interface pplr_in_if import pplr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ROW_W-1:0]           grid_row;
    logic [COL_W-1:0]           grid_column;
    logic [DAY_W-1:0]           day_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, opcode, grid_row, grid_column, day_index, sample_value,
                    input ready);
    modport sink (input valid, opcode, grid_row, grid_column, day_index, sample_value,
                  output ready);
endinterface

interface pplr_out_if import pplr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [MEAN_W-1:0]  mean_value;
    logic signed [SLOPE_W-1:0] slope_value;
    logic signed [ICPT_W-1:0]  intercept_value;
    logic signed [CORR_W-1:0]  correlation_value;
    logic [STAT_W-1:0]         fit_status;

    modport source (output valid, mean_value, slope_value, intercept_value,
                    correlation_value, fit_status, input ready);
    modport sink (input valid, mean_value, slope_value, intercept_value,
                  correlation_value, fit_status, output ready);
endinterface

>>> rtl/core/pplr_datapath.sv
// ----------------------------------------------------------------------------
// pplr_datapath: sum store and fit arithmetic
// Point store with clear sweep, accumulate update, register set and serial
// multiply, restoring divide and digit-by-digit square root units.
// ----------------------------------------------------------------------------
module pplr_datapath import pplr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_opcode,
    input  logic [ROW_W-1:0]           i_grid_row,
    input  logic [COL_W-1:0]           i_grid_column,
    input  logic [DAY_W-1:0]           i_day_index,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  t_ctl                       i_ctl,
    output t_sts                       o_sts,
    output t_result                    o_result
);

    // config register
    logic [CFG_W-1:0] r_num_days;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_days <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_num_days <= i_cfg_data;
        end
    end

    // store and read port
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROW_W-1:0]  row_sel;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // accumulate stores at the flipped row, report reads the row as given
    assign row_sel = i_opcode ? i_grid_row : (ROW_W'(GRID_ROWS - 1) - i_grid_row);
    assign rd_addr = {row_sel, i_grid_column};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_ctl.take) begin
            r_rd <= mem[rd_addr];
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // accumulate operands, products registered at accept
    logic signed [SAMPLE_W-1:0] r_v;
    logic [31:0]                r_vv;
    logic signed [25:0]         r_vd;
    logic signed [31:0]         vv;
    logic signed [25:0]         vd;

    assign vv = i_sample_value * i_sample_value;
    assign vd = i_sample_value * $signed({1'b0, i_day_index});

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_addr <= rd_addr;
            r_v    <= i_sample_value;
            r_vv   <= vv;
            r_vd   <= vd;
        end
    end

    logic [SUM_W-1:0] acc_sv;
    logic [SQ_W-1:0]  acc_sv2;
    logic [DW_W-1:0]  acc_sxv;

    assign acc_sv  = r_rd[WORD_W-1 -: SUM_W] + {{(SUM_W-SAMPLE_W){r_v[SAMPLE_W-1]}}, r_v};
    assign acc_sv2 = r_rd[DW_W +: SQ_W] + {{(SQ_W-32){1'b0}}, r_vv};
    assign acc_sxv = r_rd[DW_W-1:0] + {{(DW_W-26){r_vd[25]}}, r_vd};

    // store write: clear sweep or accumulate update
    always_comb begin
        mem_we    = i_ctl.clr | i_ctl.acc_wr;
        mem_waddr = i_ctl.clr ? r_clr_addr : r_addr;
        mem_wdata = i_ctl.clr ? '0 : {acc_sv, acc_sv2, acc_sxv};
    end

    // register set
    logic signed [DP_W-1:0] r_sv, r_sxv, r_sv2, r_n, r_np1, r_nm1, r_nn, r_nnp1;
    logic signed [DP_W-1:0] r_t, r_den, r_sx, r_a, r_b, r_num, r_vden, r_inum, r_s;
    logic signed [MEAN_W-1:0]  r_mean;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [ICPT_W-1:0]  r_icpt;
    logic signed [CORR_W-1:0]  r_corr;
    logic signed [DP_W-1:0]    a_val;
    logic signed [DP_W-1:0]    b_val;

    // operand a select
    always_comb begin
        case (i_ctl.cmd.a)
            R_ONE:    a_val = DP_W'(1);
            R_SIX:    a_val = DP_W'(6);
            R_TWELVE: a_val = DP_W'(12);
            R_C300:   a_val = DP_W'(300);
            R_SV:     a_val = r_sv;
            R_SXV:    a_val = r_sxv;
            R_SV2:    a_val = r_sv2;
            R_N:      a_val = r_n;
            R_NP1:    a_val = r_np1;
            R_NM1:    a_val = r_nm1;
            R_NN:     a_val = r_nn;
            R_NNP1:   a_val = r_nnp1;
            R_T:      a_val = r_t;
            R_DEN:    a_val = r_den;
            R_SX:     a_val = r_sx;
            R_A:      a_val = r_a;
            R_B:      a_val = r_b;
            R_NUM:    a_val = r_num;
            R_VDEN:   a_val = r_vden;
            R_INUM:   a_val = r_inum;
            R_S:      a_val = r_s;
            default:  a_val = '0;
        endcase
    end

    // operand b select
    always_comb begin
        case (i_ctl.cmd.b)
            R_ONE:    b_val = DP_W'(1);
            R_SIX:    b_val = DP_W'(6);
            R_TWELVE: b_val = DP_W'(12);
            R_C300:   b_val = DP_W'(300);
            R_SV:     b_val = r_sv;
            R_SXV:    b_val = r_sxv;
            R_SV2:    b_val = r_sv2;
            R_N:      b_val = r_n;
            R_NP1:    b_val = r_np1;
            R_NM1:    b_val = r_nm1;
            R_NN:     b_val = r_nn;
            R_NNP1:   b_val = r_nnp1;
            R_T:      b_val = r_t;
            R_DEN:    b_val = r_den;
            R_SX:     b_val = r_sx;
            R_A:      b_val = r_a;
            R_B:      b_val = r_b;
            R_NUM:    b_val = r_num;
            R_VDEN:   b_val = r_vden;
            R_INUM:   b_val = r_inum;
            R_S:      b_val = r_s;
            default:  b_val = '0;
        endcase
    end

    // shared iterative unit state
    t_unit             r_unit;
    t_reg              r_dst;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_mcand;
    logic [DP_W-1:0]   r_mplier;
    logic [PROD_W-1:0] r_prod;
    logic [DP_W-1:0]   r_quo;
    logic [DP_W-1:0]   r_rem;
    logic [DP_W-1:0]   r_div;
    logic              r_neg;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [SREM_W-1:0] r_srem;

    // divide start: magnitude scaled by fraction bits plus half divisor for rounding
    logic [DP_W-1:0] a_mag;
    logic [4:0]      div_fb;
    logic            div_rnd;
    logic [DP_W-1:0] div_start;

    assign a_mag = a_val[DP_W-1] ? DP_W'(-a_val) : DP_W'(a_val);

    always_comb begin
        case (i_ctl.cmd.dst)
            R_MEAN:  begin div_fb = 5'd8;  div_rnd = 1'b1; end
            R_SLOPE: begin div_fb = 5'd16; div_rnd = 1'b1; end
            R_ICPT:  begin div_fb = 5'd8;  div_rnd = 1'b1; end
            R_CORR:  begin div_fb = 5'd15; div_rnd = 1'b1; end
            default: begin div_fb = 5'd0;  div_rnd = 1'b0; end
        endcase
    end

    assign div_start = (a_mag << div_fb) + (div_rnd ? (DP_W'(b_val) >> 1) : '0);

    // divide step
    logic [DP_W:0] rem_sh;
    logic          rem_ge;
    assign rem_sh = {r_rem, r_quo[DP_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};

    // root step
    logic [SREM_W-1:0] srem_sh;
    logic [SREM_W-1:0] trial;
    logic              root_ge;
    assign srem_sh = {r_srem[SREM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial   = {{(SREM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
    assign root_ge = srem_sh >= trial;

    // divide finish: sign and saturation to the result field
    logic [DP_W-1:0]        sat_hi;
    logic signed [DP_W-1:0] div_res;

    always_comb begin
        case (r_dst)
            R_MEAN:  sat_hi = DP_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
            R_SLOPE: sat_hi = DP_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
            R_ICPT:  sat_hi = DP_W'((64'd1 << (ICPT_W - 1)) - 64'd1);
            R_CORR:  sat_hi = DP_W'((64'd1 << (CORR_W - 1)) - 64'd1);
            default: sat_hi = {1'b0, {(DP_W-1){1'b1}}};
        endcase
        if (!r_neg) begin
            div_res = (r_quo > sat_hi) ? $signed(sat_hi) : $signed(r_quo);
        end else begin
            div_res = (r_quo > sat_hi + DP_W'(1)) ? -$signed(sat_hi + DP_W'(1))
                                                  : -$signed(r_quo);
        end
    end

    // write-back select
    logic                   fin_mul, fin_div, fin_sqrt, alu_op;
    logic                   wr_en;
    t_reg                   wr_dst;
    logic signed [DP_W-1:0] wr_data;

    assign fin_mul  = (r_unit == U_MUL) && (r_mplier == '0);
    assign fin_div  = (r_unit == U_DIV) && (r_cnt == '0);
    assign fin_sqrt = (r_unit == U_SQRT) && (r_cnt == '0);
    assign alu_op   = i_ctl.issue && ((i_ctl.cmd.op == OP_ADD) || (i_ctl.cmd.op == OP_SUB)
                                      || (i_ctl.cmd.op == OP_SHR1));

    always_comb begin
        wr_en   = 1'b1;
        wr_dst  = r_dst;
        wr_data = '0;
        if (fin_mul) begin
            wr_data = $signed(r_acc[DP_W-1:0]);
        end else if (fin_div) begin
            wr_data = div_res;
        end else if (fin_sqrt) begin
            wr_data = $signed(DP_W'(r_root));
        end else if (alu_op) begin
            wr_dst = i_ctl.cmd.dst;
            case (i_ctl.cmd.op)
                OP_ADD:  wr_data = a_val + b_val;
                OP_SUB:  wr_data = a_val - b_val;
                OP_SHR1: wr_data = a_val >>> 1;
                default: wr_data = '0;
            endcase
        end else begin
            wr_en = 1'b0;
        end
    end

    // effective day count
    logic [CFG_W-1:0] n_eff;
    always_comb begin
        if (r_num_days == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_num_days > CFG_W'(MAX_DAYS)) begin
            n_eff = CFG_W'(MAX_DAYS);
        end else begin
            n_eff = r_num_days;
        end
    end

    // register set update
    always_ff @(posedge i_clk) begin
        if (i_ctl.rep_load) begin
            r_sv     <= DP_W'($signed(r_rd[WORD_W-1 -: SUM_W]));
            r_sv2    <= $signed({{(DP_W-SQ_W){1'b0}}, r_rd[DW_W +: SQ_W]});
            r_sxv    <= DP_W'($signed(r_rd[DW_W-1:0]));
            r_n      <= $signed({{(DP_W-CFG_W){1'b0}}, n_eff});
            r_mean   <= '0;
            r_slope  <= '0;
            r_icpt   <= '0;
            r_corr   <= '0;
        end else if (wr_en) begin
            case (wr_dst)
                R_SV:    r_sv    <= wr_data;
                R_SXV:   r_sxv   <= wr_data;
                R_SV2:   r_sv2   <= wr_data;
                R_N:     r_n     <= wr_data;
                R_NP1:   r_np1   <= wr_data;
                R_NM1:   r_nm1   <= wr_data;
                R_NN:    r_nn    <= wr_data;
                R_NNP1:  r_nnp1  <= wr_data;
                R_T:     r_t     <= wr_data;
                R_DEN:   r_den   <= wr_data;
                R_SX:    r_sx    <= wr_data;
                R_A:     r_a     <= wr_data;
                R_B:     r_b     <= wr_data;
                R_NUM:   r_num   <= wr_data;
                R_VDEN:  r_vden  <= wr_data;
                R_INUM:  r_inum  <= wr_data;
                R_S:     r_s     <= wr_data;
                R_MEAN:  r_mean  <= wr_data[MEAN_W-1:0];
                R_SLOPE: r_slope <= wr_data[SLOPE_W-1:0];
                R_ICPT:  r_icpt  <= wr_data[ICPT_W-1:0];
                R_CORR:  r_corr  <= wr_data[CORR_W-1:0];
                default: ;
            endcase
        end
    end

    // iterative unit control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= U_IDLE;
        end else begin
            case (r_unit)
                U_IDLE: begin
                    if (i_ctl.issue) begin
                        case (i_ctl.cmd.op)
                            OP_MUL:  r_unit <= U_MUL;
                            OP_DIV:  r_unit <= U_DIV;
                            OP_SQRT: r_unit <= U_SQRT;
                            default: r_unit <= U_IDLE;
                        endcase
                    end
                end
                U_MUL:   if (fin_mul) r_unit <= U_IDLE;
                U_DIV:   if (fin_div) r_unit <= U_IDLE;
                U_SQRT:  if (fin_sqrt) r_unit <= U_IDLE;
                default: r_unit <= U_IDLE;
            endcase
        end
    end

    // iterative unit data
    always_ff @(posedge i_clk) begin
        if (r_unit == U_IDLE && i_ctl.issue) begin
            r_dst    <= i_ctl.cmd.dst;
            r_acc    <= '0;
            r_mcand  <= {{DP_W{1'b0}}, a_val};
            r_mplier <= b_val;
            r_quo    <= div_start;
            r_rem    <= '0;
            r_div    <= b_val;
            r_neg    <= a_val[DP_W-1];
            r_rad    <= r_prod[RAD_W-1:0];
            r_root   <= '0;
            r_srem   <= '0;
            r_cnt    <= (i_ctl.cmd.op == OP_SQRT) ? CNT_W'(ROOT_W) : CNT_W'(DP_W);
        end else begin
            case (r_unit)
                U_MUL: begin
                    if (fin_mul) begin
                        r_prod <= r_acc;
                    end else begin
                        if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                U_DIV: begin
                    if (!fin_div) begin
                        r_rem <= rem_ge ? DP_W'(rem_sh - {1'b0, r_div}) : rem_sh[DP_W-1:0];
                        r_quo <= {r_quo[DP_W-2:0], rem_ge};
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                U_SQRT: begin
                    if (!fin_sqrt) begin
                        r_srem <= root_ge ? (srem_sh - trial) : srem_sh;
                        r_root <= {r_root[ROOT_W-2:0], root_ge};
                        r_rad  <= r_rad << 2;
                        r_cnt  <= r_cnt - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_result.mean   <= r_mean;
            o_result.slope  <= r_slope;
            o_result.icpt   <= r_icpt;
            o_result.corr   <= r_corr;
            o_result.status <= i_ctl.status;
        end
    end

    // status to controller
    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.busy     = (r_unit != U_IDLE);
    assign o_sts.cold     = (r_t <= 0);
    assign o_sts.den_le0  = (r_den <= 0);
    assign o_sts.vden_gt0 = (r_vden > 0);
    assign o_sts.s_zero   = (r_s == 0);

endmodule

>>> rtl/core/pplr_ctrl.sv
// ----------------------------------------------------------------------------
// pplr_ctrl: fit sequencer
// Clear sweep, accumulate and report sequencing, fit program and output slot.
// ----------------------------------------------------------------------------
module pplr_ctrl import pplr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_opcode,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_ctl o_ctl
);

    // fit program
    function automatic t_cmd prog(input logic [PC_W-1:0] pc);
        t_cmd c;
        case (pc)
            5'd0:    c = '{op: OP_ADD,  a: R_N,    b: R_ONE,    dst: R_NP1};
            5'd1:    c = '{op: OP_SUB,  a: R_N,    b: R_ONE,    dst: R_NM1};
            5'd2:    c = '{op: OP_MUL,  a: R_N,    b: R_N,      dst: R_NN};
            5'd3:    c = '{op: OP_MUL,  a: R_NN,   b: R_NP1,    dst: R_NNP1};
            5'd4:    c = '{op: OP_MUL,  a: R_NN,   b: R_NM1,    dst: R_T};
            5'd5:    c = '{op: OP_MUL,  a: R_T,    b: R_NP1,    dst: R_T};
            5'd6:    c = '{op: OP_DIV,  a: R_T,    b: R_TWELVE, dst: R_DEN};
            5'd7:    c = '{op: OP_MUL,  a: R_N,    b: R_NM1,    dst: R_SX};
            5'd8:    c = '{op: OP_SHR1, a: R_SX,   b: R_ONE,    dst: R_SX};
            5'd9:    c = '{op: OP_MUL,  a: R_N,    b: R_SXV,    dst: R_A};
            5'd10:   c = '{op: OP_MUL,  a: R_SX,   b: R_SV,     dst: R_B};
            5'd11:   c = '{op: OP_SUB,  a: R_A,    b: R_B,      dst: R_NUM};
            5'd12:   c = '{op: OP_MUL,  a: R_N,    b: R_SV2,    dst: R_A};
            5'd13:   c = '{op: OP_MUL,  a: R_SV,   b: R_SV,     dst: R_B};
            5'd14:   c = '{op: OP_SUB,  a: R_A,    b: R_B,      dst: R_VDEN};
            5'd15:   c = '{op: OP_MUL,  a: R_SV,   b: R_N,      dst: R_A};
            5'd16:   c = '{op: OP_MUL,  a: R_A,    b: R_NP1,    dst: R_A};
            5'd17:   c = '{op: OP_MUL,  a: R_SIX,  b: R_NUM,    dst: R_B};
            5'd18:   c = '{op: OP_SUB,  a: R_A,    b: R_B,      dst: R_INUM};
            5'd19:   c = '{op: OP_MUL,  a: R_N,    b: R_C300,   dst: R_T};
            5'd20:   c = '{op: OP_ADD,  a: R_SV,   b: R_T,      dst: R_T};
            5'd21:   c = '{op: OP_DIV,  a: R_SV,   b: R_N,      dst: R_MEAN};
            5'd22:   c = '{op: OP_DIV,  a: R_NUM,  b: R_DEN,    dst: R_SLOPE};
            5'd23:   c = '{op: OP_DIV,  a: R_INUM, b: R_NNP1,   dst: R_ICPT};
            5'd24:   c = '{op: OP_MUL,  a: R_DEN,  b: R_VDEN,   dst: R_T};
            5'd25:   c = '{op: OP_SQRT, a: R_T,    b: R_T,      dst: R_S};
            5'd26:   c = '{op: OP_DIV,  a: R_NUM,  b: R_S,      dst: R_CORR};
            default: c = '{op: OP_ADD,  a: R_ONE,  b: R_ONE,    dst: R_T};
        endcase
        return c;
    endfunction

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_status = r_status;
        case (r_state)
            S_CLEAR:    if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) n_state = i_in_opcode ? S_REP_LOAD : S_ACC_WR;
            end
            S_ACC_WR:   n_state = S_IDLE;
            S_REP_LOAD: begin
                n_state  = S_EXEC;
                n_pc     = '0;
                n_status = ST_FIT;
            end
            S_EXEC:     n_state = S_WAIT;
            S_WAIT: begin
                if (!i_sts.busy) begin
                    n_state = S_EXEC;
                    n_pc    = r_pc + PC_W'(1);
                    case (r_pc)
                        PC_MEAN: begin
                            if (i_sts.cold) begin
                                n_status = ST_COLD;
                                n_state  = S_OUT;
                            end else if (i_sts.den_le0) begin
                                n_status = ST_ZERO_DEN;
                                n_state  = S_OUT;
                            end
                        end
                        PC_ICPT:  if (!i_sts.vden_gt0) n_state = S_OUT;
                        PC_SQRT:  if (i_sts.s_zero) n_state = S_OUT;
                        PC_CORR:  n_state = S_OUT;
                        default: ;
                    endcase
                end
            end
            S_OUT:      if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_ctl.clr         = (r_state == S_CLEAR);
        o_ctl.take        = (r_state == S_IDLE) && i_in_valid;
        o_ctl.acc_wr      = (r_state == S_ACC_WR);
        o_ctl.rep_load    = (r_state == S_REP_LOAD);
        o_ctl.issue       = (r_state == S_EXEC);
        o_ctl.cmd         = prog(r_pc);
        o_ctl.out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
        o_ctl.status      = r_status;
        n_out_valid       = o_ctl.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pc        <= '0;
            r_status    <= ST_FIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.busy)
        else $error("unit busy while accepting words");

    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.issue |-> !i_sts.busy)
        else $error("command issued to busy unit");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clear sweep restarted without reset");

endmodule

>>> rtl/core/per_point_linear_regression_core.sv
// ----------------------------------------------------------------------------
// per_point_linear_regression_core: per-point day regression
// Accumulates daily samples per grid point and reports mean, slope,
// intercept and correlation of a least-squares line over the days.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  i_in      in   valid/ready      opcode, grid_row, grid_column, day_index, sample_value
//  o_out     out  valid/ready      mean, slope, intercept, correlation, fit_status
//  cfg       in   i_cfg_we         i_cfg_data = num_days
//
//  accumulate: store read, then write back of the three sums
//  report: a fit program run on the shared 1-bit serial
//  multiplier, restoring divider and 2-bit-per-step root unit
//  after reset a clear sweep zeroes the whole store; no words taken
//  a finished report waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
module per_point_linear_regression_core import pplr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    pplr_in_if.sink           i_in,
    pplr_out_if.source        o_out
);

    t_ctl    ctl;
    t_sts    sts;
    t_result result;

    pplr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctl       (ctl)
    );

    pplr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_in.opcode),
        .i_grid_row     (i_in.grid_row),
        .i_grid_column  (i_in.grid_column),
        .i_day_index    (i_in.day_index),
        .i_sample_value (i_in.sample_value),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_result       (result)
    );

    // result word onto the channel
    assign o_out.mean_value        = result.mean;
    assign o_out.slope_value       = result.slope;
    assign o_out.intercept_value   = result.icpt;
    assign o_out.correlation_value = result.corr;
    assign o_out.fit_status        = result.status;

endmodule
